@@ rtl/gsc_pkg.sv @@
package gsc_pkg;

    // Default buffer depth in entries
    localparam int unsigned CAPTURE_DEPTH_DEFAULT = 16384;

    // Result phase codes
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_ARMED = 2'd1;
    localparam logic [1:0] PHASE_FULL  = 2'd2;

    // Fault codes
    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_RATE   = 2'd1;
    localparam logic [1:0] FAULT_LAYOUT = 2'd2;

    typedef enum logic [1:0] {
        ACT_ARM     = 2'd0,
        ACT_SAMPLE  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_READ    = 2'd3
    } gsc_action_t;

    typedef enum logic [1:0] {
        REG_WANTED_EPOCH   = 2'd0,
        REG_EXPECTED_RATE  = 2'd1,
        REG_WANTED_SAMPLES = 2'd2,
        REG_SETTLE_SAMPLES = 2'd3
    } gsc_reg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] chunk_epoch;
        logic [23:0] chunk_rate;
        logic        two_channels;
        logic [47:0] sample_index;
        logic [31:0] in_phase;
        logic [31:0] quadrature;
        logic [13:0] read_address;
    } gsc_in_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [14:0] filled_count;
        logic [47:0] first_index;
        logic [1:0]  fault;
        logic [23:0] fault_rate;
        logic [31:0] read_in_phase;
        logic [31:0] read_quadrature;
        logic        complete;
    } gsc_out_t;

    typedef struct packed {
        logic [31:0] wanted_epoch;
        logic [23:0] expected_rate;
        logic [14:0] wanted_samples;
        logic [15:0] settle_samples;
    } gsc_cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [14:0] filled_count;
        logic [47:0] first_index;
        logic [1:0]  fault;
        logic [23:0] fault_rate;
        logic        complete;
    } gsc_status_t;

    typedef struct packed {
        logic        wr_en;
        logic [14:0] wr_index;
        logic [63:0] wr_word;
        logic        rd_en;
        logic [13:0] rd_address;
    } gsc_mem_req_t;

endpackage

@@ rtl/gsc_cfg_regs.sv @@
module gsc_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  gsc_pkg::gsc_reg_t   cfg_index,
    input  logic [31:0]         cfg_data,
    output gsc_pkg::gsc_cfg_t   cfg
);
    import gsc_pkg::*;

    gsc_cfg_t cfg_reg;
    gsc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WANTED_EPOCH:   cfg_next.wanted_epoch   = cfg_data;
                REG_EXPECTED_RATE:  cfg_next.expected_rate  = cfg_data[23:0];
                REG_WANTED_SAMPLES: cfg_next.wanted_samples = cfg_data[14:0];
                REG_SETTLE_SAMPLES: cfg_next.settle_samples = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wanted_epoch   <= '0;
            cfg_reg.expected_rate  <= '0;
            cfg_reg.wanted_samples <= 15'd16384;
            cfg_reg.settle_samples <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/gsc_store.sv @@
module gsc_store #(
    parameter int unsigned CAPTURE_DEPTH = gsc_pkg::CAPTURE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  gsc_pkg::gsc_mem_req_t req,
    output logic [63:0]           rd_word
);
    import gsc_pkg::*;

    localparam int unsigned AW = $clog2(CAPTURE_DEPTH);

    logic [63:0]   mem [CAPTURE_DEPTH];
    logic [63:0]   rd_word_reg;
    logic          rd_hit_reg;
    logic          rd_hit;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // addresses past the end of the buffer read back as zero
    assign rd_hit  = req.rd_en && (32'(req.rd_address) < CAPTURE_DEPTH);
    assign wr_addr = AW'(req.wr_index);
    assign rd_addr = AW'(req.rd_address);

    always_ff @(posedge aclk) begin
        if (step && req.wr_en) begin
            mem[wr_addr] <= req.wr_word;
        end
        if (step && rd_hit) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg <= 1'b0;
        end else if (step) begin
            rd_hit_reg <= rd_hit;
        end
    end

    assign rd_word = rd_hit_reg ? rd_word_reg : 64'd0;

endmodule

@@ rtl/gsc_ctrl.sv @@
module gsc_ctrl #(
    parameter int unsigned CAPTURE_DEPTH = gsc_pkg::CAPTURE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  gsc_pkg::gsc_in_t       item,
    input  gsc_pkg::gsc_cfg_t      cfg,
    output gsc_pkg::gsc_status_t   status,
    output gsc_pkg::gsc_mem_req_t  mem_req
);
    import gsc_pkg::*;

    localparam int unsigned DEPTH_CAP = (CAPTURE_DEPTH > 32767) ? 32767 : CAPTURE_DEPTH;
    localparam logic [14:0] GOAL_MAX  = 15'(DEPTH_CAP);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ARMED = 3'b010,
        ST_FULL  = 3'b100
    } gsc_state_t;

    gsc_state_t  state_reg,    state_next;
    logic [15:0] settle_reg,   settle_next;
    logic [14:0] count_reg,    count_next;
    logic [47:0] first_reg,    first_next;
    logic [1:0]  fault_reg,    fault_next;
    logic [23:0] bad_rate_reg, bad_rate_next;
    logic        complete_reg, complete_next;
    logic [14:0] goal;
    logic [1:0]  phase_code;

    // wanted count clamps to the buffer depth
    assign goal = (cfg.wanted_samples > GOAL_MAX) ? GOAL_MAX : cfg.wanted_samples;

    always_comb begin
        state_next    = state_reg;
        settle_next   = settle_reg;
        count_next    = count_reg;
        first_next    = first_reg;
        fault_next    = fault_reg;
        bad_rate_next = bad_rate_reg;

        mem_req.wr_en      = 1'b0;
        mem_req.wr_index   = count_reg;
        mem_req.wr_word    = {item.in_phase, item.quadrature};
        mem_req.rd_en      = 1'b0;
        mem_req.rd_address = item.read_address;

        unique case (gsc_action_t'(item.action))
            ACT_ARM: begin
                state_next    = ST_ARMED;
                settle_next   = cfg.settle_samples;
                count_next    = '0;
                first_next    = '0;
                fault_next    = FAULT_NONE;
                bad_rate_next = '0;
            end
            ACT_SAMPLE: begin
                // stale epochs and samples outside armed are dropped
                if (state_reg == ST_ARMED && item.chunk_epoch >= cfg.wanted_epoch) begin
                    if (item.chunk_rate != cfg.expected_rate) begin
                        fault_next    = FAULT_RATE;
                        bad_rate_next = item.chunk_rate;
                        state_next    = ST_FULL;
                    end else if (!item.two_channels) begin
                        fault_next    = FAULT_LAYOUT;
                        bad_rate_next = '0;
                        state_next    = ST_FULL;
                    end else begin
                        if (settle_reg != 16'd0) begin
                            settle_next = settle_reg - 16'd1;
                        end else if (count_reg < goal) begin
                            if (count_reg == 15'd0) begin
                                first_next = item.sample_index;
                            end
                            mem_req.wr_en = 1'b1;
                            count_next    = count_reg + 15'd1;
                        end
                        if (count_next >= goal) begin
                            state_next = ST_FULL;
                        end
                    end
                end
            end
            ACT_RELEASE: begin
                state_next = ST_IDLE;
            end
            ACT_READ: begin
                mem_req.rd_en = 1'b1;
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        complete_next = (state_next == ST_FULL) && (fault_next == FAULT_NONE)
                        && (count_next >= goal);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            settle_reg   <= '0;
            count_reg    <= '0;
            first_reg    <= '0;
            fault_reg    <= FAULT_NONE;
            bad_rate_reg <= '0;
            complete_reg <= 1'b0;
        end else if (step) begin
            state_reg    <= state_next;
            settle_reg   <= settle_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            fault_reg    <= fault_next;
            bad_rate_reg <= bad_rate_next;
            complete_reg <= complete_next;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  phase_code = PHASE_IDLE;
            ST_ARMED: phase_code = PHASE_ARMED;
            ST_FULL:  phase_code = PHASE_FULL;
            default:  phase_code = PHASE_IDLE;
        endcase
    end

    assign status.phase        = phase_code;
    assign status.filled_count = count_reg;
    assign status.first_index  = first_reg;
    assign status.fault        = fault_reg;
    assign status.fault_rate   = bad_rate_reg;
    assign status.complete     = complete_reg;

endmodule

@@ rtl/gated_sample_capture_top.sv @@
// Path: an accepted item sits in the input register, then moves into the state/result registers.
// Throughput: 1 item per cycle while m_ready is high; state update and buffer use one pass per item.
// Reset: aresetn synchronous, active low; clears phase to idle, counters, fault and handshakes.
// Config registers return to their defaults; the sample buffer is not cleared and
// entries read back before being written are undefined.
module gated_sample_capture_top #(
    parameter int unsigned CAPTURE_DEPTH = gsc_pkg::CAPTURE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,

    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  gsc_pkg::gsc_in_t   s_item,

    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output gsc_pkg::gsc_out_t  m_item,

    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  gsc_pkg::gsc_reg_t  cfg_index,
    input  logic [31:0]        cfg_data
);
    import gsc_pkg::*;

    gsc_in_t      in_item_reg;
    logic         in_vld_reg;
    logic         m_valid_reg;
    logic         advance;
    gsc_cfg_t     cfg;
    gsc_status_t  status;
    gsc_mem_req_t mem_req;
    logic [63:0]  rd_word;

    // Registers are always writable; writes must only arrive while the block is quiet (not enforced here).
    assign cfg_ready = 1'b1;

    // An item moves from the input register into the state/result registers
    // whenever the result slot is empty or being drained this cycle.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);

    // Input register refills in the same cycle it hands its item forward.
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    gsc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Capture state lives here; it only moves on advance, so between advances
    // it is exactly the status of the item sitting in the result slot.
    gsc_ctrl #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .status  (status),
        .mem_req (mem_req)
    );

    // Sample buffer: at most one write or one registered read per item.
    gsc_store #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (mem_req),
        .rd_word (rd_word)
    );

    assign m_valid                = m_valid_reg;
    assign m_item.phase           = status.phase;
    assign m_item.filled_count    = status.filled_count;
    assign m_item.first_index     = status.first_index;
    assign m_item.fault           = status.fault;
    assign m_item.fault_rate      = status.fault_rate;
    assign m_item.read_in_phase   = rd_word[63:32];
    assign m_item.read_quadrature = rd_word[31:0];
    assign m_item.complete        = status.complete;

`ifndef SYNTHESIS
    // a forwarded item always lands in the result slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result slot empty after advance");

    // a stalled result must not see its status change underneath it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(status))
        else $error("capture status moved while result stalled");

    // complete only when full with no fault
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_item.complete || (m_item.phase == PHASE_FULL && m_item.fault == FAULT_NONE))
        else $error("complete flagged outside a clean full capture");

    // a recorded fault never leaves the block armed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_item.fault == FAULT_NONE) || (m_item.phase != PHASE_ARMED))
        else $error("armed with a fault recorded");
`endif

endmodule
